/* hw/rtl/bpa_pkg.sv */
// Package for the next-fit bitmap page allocator.
// Holds the request kind codes, the engine state enum and shared widths.
`timescale 1ns / 1ps
package bpa_pkg;
	localparam int CNT_W = 17;
	localparam int PG_W  = 16;

	typedef enum logic {
		KIND_ALLOC = 1'b0,
		KIND_FREE  = 1'b1
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_MARK_RD,
		ST_MARK_WR,
		ST_FREE_RD,
		ST_FREE_WR,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic           re;
		logic           we;
	} mem_ctl_t;
endpackage

/* hw/rtl/bpa_map_ram.sv */
// Used-map storage: one word of WORD_W page bits per row, registered read.
// Depends on bpa_pkg for the control struct.
`timescale 1ns / 1ps
module bpa_map_ram import bpa_pkg::*; #(
	parameter int ROWS   = 2048,
	parameter int WORD_W = 32,
	parameter int AW     = 11
) (
	input  logic              clk,
	input  mem_ctl_t          ctl,
	input  logic [AW-1:0]     addr,
	input  logic [WORD_W-1:0] wdata,
	output logic [WORD_W-1:0] rdata
);
	logic [WORD_W-1:0] mem [ROWS];

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[addr] <= wdata;
		end
		if (ctl.re) begin
			rdata <= mem[addr];
		end
	end
endmodule

/* hw/rtl/bitmap_page_allocator_next_fit.sv */
// Next-fit bitmap page allocator, top level.
// Channels: s_axis (request), m_axis (result), cfg (usable page count).
// Request tdata from bit 0: start_page[15:0], page_count[32:16], pad to 40 bits;
// tuser carries kind (0 allocate, 1 free). Result tdata: run_start[15:0];
// tuser carries status (0 success, 1 out of memory).
// One request is worked at a time. The used map sits in a 32-bit-wide
// synchronous RAM; a scan reads each row in a read state and then checks the
// row's pages one per cycle straight from the RAM output, in both passes, and
// marking reads each row touched and writes it back. A free reads and writes
// back each row in its clipped range.
// Every request passes through the done state before its result is shown.
// Reset sweeps the RAM to all ones, one row a cycle;
// requests are held off meanwhile, config writes are taken at any time.
// A result waits in an output register; the engine stalls until it is taken,
// and the next request is accepted in the cycle after the result leaves.
`timescale 1ns / 1ps
module bitmap_page_allocator_next_fit import bpa_pkg::*; #(
	parameter int NUM_PAGES = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // start_page, page_count, zero pad
	input  logic        s_axis_tuser,  // kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // run_start
	output logic        m_axis_tuser,  // status
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [16:0] cfg_data
);
	localparam int WORD_W = 32;
	localparam int ROWS   = (NUM_PAGES + WORD_W - 1) / WORD_W;
	localparam int AW     = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int PW     = ($clog2(NUM_PAGES + 1) > CNT_W) ? $clog2(NUM_PAGES + 1) : CNT_W;
	localparam int BW     = $clog2(WORD_W);
	localparam logic [PW-1:0] NP = PW'(NUM_PAGES);

	state_t state_q, state_d;
	logic [PW-1:0]  pos_q, lim_w, second_q, stop_q, cur_q, end_q, run_q, cnt_q;
	logic           pass2_q;
	logic [CNT_W-1:0] usable_q;
	logic [AW-1:0]  clr_q;
	logic [WORD_W-1:0] rdata, wdata;
	logic [AW-1:0]  addr;
	mem_ctl_t       ctl;
	logic           out_v_q, out_st_q;
	logic [PG_W-1:0] out_rs_q;
	kind_t          kind;
	logic           accept;
	logic [PW-1:0]  req_start, req_cnt;
	logic [PW-1:0]  run_inc, run_first, next_row;
	logic           scan_hit;
	logic [WORD_W-1:0] range_mask;
	logic           cur_bit;

	assign kind  = kind_t'(s_axis_tuser);
	assign lim_w = (32'(usable_q) > 32'(NUM_PAGES)) ? NP : PW'(usable_q);
	assign cfg_ready = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE) && !out_v_q;
	assign accept = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_rs_q;
	assign m_axis_tuser  = out_st_q;

	bpa_map_ram #(.ROWS(ROWS), .WORD_W(WORD_W), .AW(AW)) u_ram (
		.clk(clk), .ctl(ctl), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	assign req_start = PW'(s_axis_tdata[15:0]);
	assign req_cnt   = PW'(s_axis_tdata[32:16]);

	// pages of the current row covered by [cur_q, end_q)
	always_comb begin
		for (int b = 0; b < WORD_W; b++) begin
			range_mask[b] = ({cur_q[PW-1:BW], BW'(b)} >= cur_q)
				&& ({cur_q[PW-1:BW], BW'(b)} < end_q);
		end
	end

	// RAM output holds the row read in the last scan read cycle
	assign cur_bit   = rdata[cur_q[BW-1:0]];
	assign run_inc   = run_q + 1'b1;
	assign run_first = cur_q + 1'b1 - cnt_q;
	assign scan_hit  = !cur_bit && (run_inc == cnt_q);
	assign next_row  = {cur_q[PW-1:BW] + (PW-BW)'(1), {BW{1'b0}}};

	always_comb begin
		state_d = state_q;
		ctl = '0;
		addr = AW'(cur_q >> BW);
		wdata = rdata;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (kind == KIND_FREE)
						state_d = (req_start < lim_w && req_cnt != '0) ? ST_FREE_RD : ST_DONE;
					else
						state_d = (req_cnt == '0) ? ST_DONE : ST_SCAN_RD;
				end
			end
			ST_CLEAR: begin
				ctl.we = 1'b1;
				addr = clr_q;
				wdata = '1;
				if (clr_q == AW'(ROWS - 1)) state_d = ST_IDLE;
			end
			ST_SCAN_RD: begin
				ctl.re = 1'b1;
				state_d = ST_SCAN_CHK;
			end
			ST_SCAN_CHK: begin
				if (cur_q >= stop_q) begin
					state_d = pass2_q ? ST_DONE : ST_SCAN_RD;
				end else if (scan_hit) begin
					state_d = ST_MARK_RD;
				end else if (cur_q[BW-1:0] == '1) begin
					// next page sits in another row: refetch
					state_d = ST_SCAN_RD;
				end
			end
			ST_MARK_RD, ST_FREE_RD: begin
				ctl.re = 1'b1;
				state_d = (state_q == ST_MARK_RD) ? ST_MARK_WR : ST_FREE_WR;
			end
			ST_MARK_WR: begin
				ctl.we = 1'b1;
				wdata = rdata | range_mask;
				state_d = (next_row >= end_q) ? ST_DONE : ST_MARK_RD;
			end
			ST_FREE_WR: begin
				ctl.we = 1'b1;
				wdata = rdata & ~range_mask;
				state_d = (next_row >= end_q) ? ST_DONE : ST_FREE_RD;
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			pos_q    <= '0;
			usable_q <= 17'd65536;
			out_v_q  <= 1'b0;
			out_st_q <= 1'b0;
			out_rs_q <= '0;
			cur_q    <= '0;
			end_q    <= '0;
			second_q <= '0;
			stop_q   <= '0;
			run_q    <= '0;
			cnt_q    <= '0;
			pass2_q  <= 1'b0;
		end else begin
			if (cfg_valid) usable_q <= cfg_data;
			if (out_v_q && m_axis_tready) out_v_q <= 1'b0;
			state_q <= state_d;
			case (state_q)
				ST_CLEAR: clr_q <= clr_q + 1'b1;
				ST_IDLE: begin
					if (accept) begin
						out_st_q <= 1'b0;
						out_rs_q <= '0;
						if (kind == KIND_FREE) begin
							cur_q <= req_start;
							end_q <= ((PW+1)'(req_start) + (PW+1)'(req_cnt) > (PW+1)'(lim_w))
								? lim_w : PW'(req_start + req_cnt);
						end else begin
							cnt_q    <= req_cnt;
							second_q <= (pos_q < lim_w) ? pos_q : lim_w;
							cur_q    <= pos_q;
							stop_q   <= lim_w;
							run_q    <= '0;
							pass2_q  <= 1'b0;
							if (req_cnt == '0) begin
								pos_q    <= (pos_q < lim_w) ? pos_q : lim_w;
								out_st_q <= 1'b1;
							end
						end
					end
				end
				ST_SCAN_CHK: begin
					if (cur_q >= stop_q) begin
						// pass ended without a hit
						if (!pass2_q) begin
							pass2_q <= 1'b1;
							cur_q   <= '0;
							stop_q  <= second_q;
							run_q   <= '0;
						end else begin
							pos_q    <= second_q;
							out_st_q <= 1'b1;
						end
					end else if (scan_hit) begin
						out_rs_q <= PG_W'(run_first);
						pos_q    <= cur_q + 1'b1;
						end_q    <= cur_q + 1'b1;
						cur_q    <= run_first;
					end else begin
						run_q <= cur_bit ? '0 : run_inc;
						cur_q <= cur_q + 1'b1;
					end
				end
				ST_MARK_WR, ST_FREE_WR: cur_q <= next_row;
				ST_DONE: out_v_q <= 1'b1;
				default: ;
			endcase
		end
	end

`ifndef SYNTH
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_axis_tready)
		else $error("request accepted while engine busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !m_axis_tready) |=> out_v_q && $stable(out_rs_q))
		else $error("result dropped under stall");
	a_pos_le_np: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= NP)
		else $error("search position past page count");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_st_q) |-> (out_rs_q == '0))
		else $error("failed allocate carries a page");
`endif
endmodule

/* tb/sv/tb_top.sv */
// Testbench for the next-fit bitmap page allocator: random and directed stream traffic.
// Depends on bpa_pkg and bitmap_page_allocator_next_fit; a scoreboard class predicts results.
`timescale 1ns / 1ps
module tb_top import bpa_pkg::*; ();

	class alloc_scoreboard;
		bit used_map [65536];
		int search_pos;
		int page_limit;
		bit exp_status [$];
		bit [15:0] exp_start [$];
		int mismatches;
		int results_seen;

		function void reset_state();
			foreach (used_map[i]) used_map[i] = 1'b1;
			search_pos = 0;
			page_limit = 65536;
		endfunction

		function void set_limit(bit [16:0] v);
			page_limit = v;
		endfunction

		// next-fit pass from search_pos to stop; marks the run on a hit
		function bit scan(int count, int stop, output int first);
			int run;
			run = 0;
			first = 0;
			while (search_pos < stop) begin
				search_pos++;
				if (!used_map[search_pos - 1]) begin
					run++;
					if (run == count) begin
						first = search_pos - count;
						for (int i = first; i < search_pos; i++) used_map[i] = 1'b1;
						return 1'b1;
					end
				end else begin
					run = 0;
				end
			end
			return 1'b0;
		endfunction

		function void note_request(kind_t kind, bit [15:0] start, bit [16:0] count);
			int lim, second, first, last;
			bit hit;
			lim = (page_limit > 65536) ? 65536 : page_limit;
			if (kind == KIND_FREE) begin
				last = int'(start) + int'(count);
				if (last > lim) last = lim;
				for (int i = start; i < last; i++) used_map[i] = 1'b0;
				exp_status.push_back(1'b0);
				exp_start.push_back(16'd0);
				return;
			end
			second = (search_pos < lim) ? search_pos : lim;
			hit = 1'b0;
			first = 0;
			if (count != 0) begin
				hit = scan(count, lim, first);
				if (!hit) begin
					search_pos = 0;
					hit = scan(count, second, first);
				end
			end
			if (!hit) begin
				search_pos = second;
				exp_status.push_back(1'b1);
				exp_start.push_back(16'd0);
			end else begin
				exp_status.push_back(1'b0);
				exp_start.push_back(first[15:0]);
			end
		endfunction

		function void check_result(bit status, bit [15:0] run_start);
			bit es;
			bit [15:0] er;
			results_seen++;
			if (exp_status.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result: status %0d run_start %0d",
					status, run_start);
				return;
			end
			es = exp_status.pop_front();
			er = exp_start.pop_front();
			if (es != status || er != run_start) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch %0d: expected status %0d run_start %0d, got %0d %0d",
						results_seen, es, er, status, run_start);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;  // start_page[15:0], page_count[32:16], zero pad
	logic        s_axis_tuser;  // kind
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;  // run_start
	logic        m_axis_tuser;  // status
	logic        cfg_valid;
	logic        cfg_ready;
	logic [16:0] cfg_data;

	alloc_scoreboard sb;
	bit quiet;
	int sent_allocs, sent_frees;

	bitmap_page_allocator_next_fit #(.NUM_PAGES(65536)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5s;
		$display("timeout waiting for results");
		$display("** bitmap_page_allocator_next_fit: FAILED **");
		$finish;
	end

	// result side: random stall bursts, sample at the rising edge
	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				m_axis_tready = 1'b0;
				repeat ($urandom_range(1, 3) - 1) @(negedge clk);
			end else begin
				m_axis_tready = 1'b1;
			end
		end
	end

	always @(posedge clk)
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tuser, m_axis_tdata);

	task automatic send_request(kind_t kind, bit [15:0] start, bit [16:0] count);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid = 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser  = kind;
		s_axis_tdata  = {7'd0, count, start};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(kind, start, count);
		if (kind == KIND_FREE) sent_frees++; else sent_allocs++;
		@(negedge clk);
		s_axis_tvalid = 1'b0;
	endtask

	task automatic write_limit(bit [16:0] v);
		while (sb.exp_status.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_data  = v;
		do @(posedge clk); while (!cfg_ready);
		sb.set_limit(v);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic random_phase(int lim, int n);
		int r, top;
		top = (lim > 65536) ? 65536 : lim;
		repeat (n) begin
			r = $urandom_range(0, 9);
			if (r == 0) begin
				// noise: any field values at all
				send_request(kind_t'($urandom_range(0, 1)), 16'($urandom),
					17'($urandom));
			end else if (r <= 3 || top == 0) begin
				if ($urandom_range(0, 7) == 0)
					send_request(KIND_FREE, 16'd0, 17'(top));
				else
					send_request(KIND_FREE, 16'($urandom_range(0, top > 0 ? top - 1 : 0)),
						17'($urandom_range(1, top / 4 + 1)));
			end else begin
				send_request(KIND_ALLOC, 16'($urandom),
					17'($urandom_range(1, top < 32 ? top + 1 : 32)));
			end
		end
	endtask

	initial begin
		int limits [8] = '{300, 0, 1, 64, 512, 65536, 17, 200};
		sb = new();
		sb.reset_state();
		quiet = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// directed: everything used after reset, then full-range cases
		send_request(KIND_ALLOC, 16'd0, 17'd0);
		send_request(KIND_ALLOC, 16'hffff, 17'd1);
		send_request(KIND_FREE, 16'hffff, 17'h1ffff);
		send_request(KIND_FREE, 16'd0, 17'd65536);
		send_request(KIND_FREE, 16'd0, 17'd65536);
		send_request(KIND_ALLOC, 16'd0, 17'd1);
		send_request(KIND_ALLOC, 16'd0, 17'd65535);
		send_request(KIND_ALLOC, 16'd0, 17'd1);
		send_request(KIND_FREE, 16'd100, 17'd8);
		send_request(KIND_ALLOC, 16'd0, 17'd65536);
		send_request(KIND_ALLOC, 16'd0, 17'd4);
		send_request(KIND_ALLOC, 16'd0, 17'd4);
		send_request(KIND_FREE, 16'd0, 17'd0);
		send_request(KIND_FREE, 16'd0, 17'd65536);
		write_limit(17'd40);
		send_request(KIND_ALLOC, 16'd0, 17'd41);
		send_request(KIND_ALLOC, 16'd0, 17'd40);
		send_request(KIND_FREE, 16'd30, 17'd100);
		send_request(KIND_ALLOC, 16'd0, 17'd10);
		send_request(KIND_FREE, 16'd5, 17'd10);
		write_limit(17'd20);
		send_request(KIND_ALLOC, 16'd0, 17'd3);
		write_limit(17'h1ffff);
		send_request(KIND_FREE, 16'hfff0, 17'h1ffff);
		send_request(KIND_ALLOC, 16'd0, 17'd16);

		foreach (limits[i]) begin
			write_limit(17'(limits[i]));
			if (i == 7) quiet = 1'b1;
			random_phase(limits[i], limits[i] == 65536 ? 60 : 160);
		end

		while (sb.exp_status.size() != 0) @(negedge clk);
		repeat (500) @(negedge clk);
		$display("covered %0d allocate and %0d free requests over %0d limit settings",
			sent_allocs, sent_frees, 12);
		$display("results checked: %0d, mismatches: %0d", sb.results_seen, sb.mismatches);
		if (sb.mismatches == 0 && sb.exp_status.size() == 0)
			$display("** bitmap_page_allocator_next_fit: PASSED **");
		else
			$display("** bitmap_page_allocator_next_fit: FAILED **");
		$finish;
	end
endmodule

/* bitmap_page_allocator_next_fit.f */
hw/rtl/bpa_pkg.sv
hw/rtl/bpa_map_ram.sv
hw/rtl/bitmap_page_allocator_next_fit.sv
tb/sv/tb_top.sv
